FILE: rtl/svalloc_pkg.sv
package svalloc_pkg;

   // Voice row size and derived widths
   localparam int VOICES = 16;
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int CMP_W  = (VIDX_W > 4) ? VIDX_W : 4;
   localparam int SAT_W  = CNT_W + 5;

   // MIDI constants
   localparam logic [6:0]  PEDAL_CC    = 7'd64;
   localparam logic [6:0]  PEDAL_ON    = 7'd64;
   localparam logic [13:0] BEND_CENTRE = 14'd8192;

   // Register indexes, taken from csr_paddr[2]
   localparam logic REG_CHANNEL_MASK = 1'b0;
   localparam logic REG_OMNI_MODE    = 1'b1;

   // Request command codes
   typedef enum logic [2:0] {
      CMD_NOTE_ON        = 3'd0,
      CMD_NOTE_OFF       = 3'd1,
      CMD_CONTROL_CHANGE = 3'd2,
      CMD_PITCH_BEND     = 3'd3,
      CMD_RELEASE_VOICE  = 3'd4,
      CMD_RELEASE_ALL    = 3'd5,
      CMD_READ_VOICE     = 3'd6
   } cmd_code_type;

   // Operation carried out by the voice cells while the scan record passes
   typedef enum logic [2:0] {
      OP_NONE,
      OP_FIND,
      OP_PEDAL_UP,
      OP_BEND,
      OP_REL_ONE,
      OP_REL_ALL,
      OP_READ
   } op_type;

   // Single-voice write after a note scan
   typedef enum logic [1:0] {
      WR_NOTE_ON,
      WR_HOLD,
      WR_RELEASE
   } wr_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_DONE
   } state_type;

   // Command broadcast to every cell
   typedef struct packed {
      op_type      op;
      logic [3:0]  ch;
      logic [6:0]  key;
      logic [6:0]  vel;
      logic [3:0]  sel;
      logic [31:0] start;
      logic [13:0] bend;
      logic        omni;
   } cmd_type;

   // Write strobe to one cell
   typedef struct packed {
      logic              en;
      logic [VIDX_W-1:0] idx;
      wr_mode_type       mode;
   } wr_type;

   // Record handed from cell to cell during a scan
   typedef struct packed {
      logic              valid;
      logic              note_found;
      logic [VIDX_W-1:0] note_idx;
      logic              free_found;
      logic [VIDX_W-1:0] free_idx;
      logic              nh_found;
      logic [VIDX_W-1:0] nh_idx;
      logic [31:0]       nh_start;
      logic              old_found;
      logic [VIDX_W-1:0] old_idx;
      logic [31:0]       old_start;
      logic              rel_hit;
      logic [VIDX_W-1:0] rel_first;
      logic [CNT_W-1:0]  rel_cnt;
      logic [CNT_W-1:0]  active;
      logic              rd_hit;
      logic              rd_active;
      logic              rd_held;
      logic [6:0]        rd_key;
      logic [6:0]        rd_vel;
      logic [3:0]        rd_chan;
      logic [13:0]       rd_bend;
   } scan_type;

   // Registered response
   typedef struct packed {
      logic [3:0]  voice_index;
      logic        voice_hit;
      logic        voice_stolen;
      logic [4:0]  released_count;
      logic [4:0]  active_count;
      logic        filtered;
      logic        rd_active;
      logic        rd_sustained;
      logic [6:0]  rd_note;
      logic [6:0]  rd_velocity;
      logic [3:0]  rd_channel;
      logic [13:0] rd_bend;
   } rsp_type;

   // 4-bit voice select against a cell index
   function automatic logic sel_match(input logic [3:0] sel, input logic [VIDX_W-1:0] id);
      return CMP_W'(sel) == CMP_W'(id);
   endfunction

   // Voice index as reported, low four bits
   function automatic logic [3:0] idx_to_out(input logic [VIDX_W-1:0] idx);
      logic [CMP_W-1:0] w;
      w = CMP_W'(idx);
      return w[3:0];
   endfunction

   // Count saturated to 31
   function automatic logic [4:0] sat_count(input logic [CNT_W-1:0] n);
      logic [SAT_W-1:0] w;
      w = SAT_W'(n);
      return (w > SAT_W'(31)) ? 5'd31 : w[4:0];
   endfunction

endpackage

FILE: rtl/svalloc_cell.sv
module svalloc_cell import svalloc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [VIDX_W-1:0] cell_id,
   input  cmd_type           cmd,
   input  wr_type            wr,
   input  scan_type          prev_rec,
   output scan_type          next_rec
);

   logic              on_ff, on_in;
   logic              held_ff, held_in;
   logic [6:0]        key_ff, key_in;
   logic [6:0]        vel_ff, vel_in;
   logic [3:0]        chan_ff, chan_in;
   logic [31:0]       start_ff, start_in;
   logic [13:0]       bend_ff, bend_in;
   scan_type          rec_ff, rec_in;

   // Scan step on the passing record, then the single-voice write port
   always_comb begin
      on_in    = on_ff;
      held_in  = held_ff;
      key_in   = key_ff;
      vel_in   = vel_ff;
      chan_in  = chan_ff;
      start_in = start_ff;
      bend_in  = bend_ff;
      rec_in   = prev_rec;

      if (prev_rec.valid) begin
         unique case (cmd.op)
            OP_FIND: begin
               // note lookup, first free, oldest non-held, oldest overall
               if (on_ff && key_ff == cmd.key && (chan_ff == cmd.ch || cmd.omni)
                   && !prev_rec.note_found) begin
                  rec_in.note_found = 1'b1;
                  rec_in.note_idx   = cell_id;
               end
               if (!on_ff && !prev_rec.free_found) begin
                  rec_in.free_found = 1'b1;
                  rec_in.free_idx   = cell_id;
               end
               if (!held_ff && (!prev_rec.nh_found || start_ff < prev_rec.nh_start)) begin
                  rec_in.nh_found = 1'b1;
                  rec_in.nh_idx   = cell_id;
                  rec_in.nh_start = start_ff;
               end
               if (!prev_rec.old_found || start_ff < prev_rec.old_start) begin
                  rec_in.old_found = 1'b1;
                  rec_in.old_idx   = cell_id;
                  rec_in.old_start = start_ff;
               end
            end
            OP_PEDAL_UP: begin
               if (on_ff && held_ff && chan_ff == cmd.ch) begin
                  on_in   = 1'b0;
                  held_in = 1'b0;
                  if (!prev_rec.rel_hit) begin
                     rec_in.rel_first = cell_id;
                  end
                  rec_in.rel_hit = 1'b1;
                  rec_in.rel_cnt = prev_rec.rel_cnt + CNT_W'(1);
               end
            end
            OP_BEND: begin
               if (on_ff && chan_ff == cmd.ch) begin
                  bend_in = cmd.bend;
               end
            end
            OP_REL_ONE: begin
               if (sel_match(cmd.sel, cell_id) && on_ff) begin
                  on_in          = 1'b0;
                  held_in        = 1'b0;
                  rec_in.rel_hit = 1'b1;
                  rec_in.rel_cnt = prev_rec.rel_cnt + CNT_W'(1);
               end
            end
            OP_REL_ALL: begin
               if (on_ff) begin
                  on_in          = 1'b0;
                  rec_in.rel_cnt = prev_rec.rel_cnt + CNT_W'(1);
               end
               held_in = 1'b0;
            end
            OP_READ: begin
               if (sel_match(cmd.sel, cell_id)) begin
                  rec_in.rd_hit    = 1'b1;
                  rec_in.rd_active = on_ff;
                  rec_in.rd_held   = held_ff;
                  rec_in.rd_key    = key_ff;
                  rec_in.rd_vel    = vel_ff;
                  rec_in.rd_chan   = chan_ff;
                  rec_in.rd_bend   = bend_ff;
               end
            end
            OP_NONE: begin
            end
            default: begin
            end
         endcase
         // running count of voices left active
         rec_in.active = prev_rec.active + CNT_W'(on_in);
      end

      // write port, used only while no record is in flight
      if (wr.en && wr.idx == cell_id) begin
         unique case (wr.mode)
            WR_NOTE_ON: begin
               on_in    = 1'b1;
               held_in  = 1'b0;
               key_in   = cmd.key;
               vel_in   = cmd.vel;
               chan_in  = cmd.ch;
               start_in = cmd.start;
               bend_in  = cmd.bend;
            end
            WR_HOLD: begin
               held_in = 1'b1;
            end
            WR_RELEASE: begin
               on_in   = 1'b0;
               held_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff    <= 1'b0;
         held_ff  <= 1'b0;
         key_ff   <= '0;
         vel_ff   <= '0;
         chan_ff  <= '0;
         start_ff <= '0;
         bend_ff  <= BEND_CENTRE;
         rec_ff   <= '0;
      end else begin
         on_ff    <= on_in;
         held_ff  <= held_in;
         key_ff   <= key_in;
         vel_ff   <= vel_in;
         chan_ff  <= chan_in;
         start_ff <= start_in;
         bend_ff  <= bend_in;
         rec_ff   <= rec_in;
      end
   end

   assign next_rec = rec_ff;

endmodule

FILE: rtl/svalloc_ctrl.sv
module svalloc_ctrl import svalloc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_data1,
   input  logic [6:0]  req_data2,
   input  logic [3:0]  req_voice_sel,
   input  logic [31:0] req_now,
   input  logic [15:0] channel_mask,
   input  logic        omni_mode,
   output cmd_type     cmd,
   output scan_type    seed,
   input  scan_type    tail,
   output wr_type      wr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);

   state_type    state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   logic         seed_valid_ff, seed_valid_in;
   logic         note_on_ff, note_on_in;
   logic         pedal_ff, pedal_in;
   logic         filt_ff, filt_in;
   scan_type     res_ff, res_in;
   logic [15:0]  chan_pedal_ff, chan_pedal_in;
   logic [13:0]  chan_bend_ff [16];
   logic [13:0]  chan_bend_in [16];
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   cmd_code_type      code;
   logic [VIDX_W-1:0] target;
   logic              stolen;
   logic [CNT_W-1:0]  act;
   rsp_type           result;
   logic              req_take;

   // Request decode
   always_comb begin
      code       = cmd_code_type'(req_cmd);
      filt_in    = (code == CMD_NOTE_ON || code == CMD_NOTE_OFF ||
                    code == CMD_CONTROL_CHANGE || code == CMD_PITCH_BEND) &&
                   !channel_mask[req_channel];
      cmd_in.ch    = req_channel;
      cmd_in.key   = req_data1;
      cmd_in.vel   = req_data2;
      cmd_in.sel   = req_voice_sel;
      cmd_in.start = req_now;
      cmd_in.bend  = chan_bend_ff[req_channel];
      cmd_in.omni  = omni_mode;
      cmd_in.op    = OP_NONE;
      note_on_in   = 1'b0;
      pedal_in     = chan_pedal_ff[req_channel];
      priority if (filt_in) begin
         cmd_in.op = OP_NONE;
      end else begin
         unique case (code)
            CMD_NOTE_ON: begin
               cmd_in.op  = OP_FIND;
               note_on_in = (req_data2 != 7'd0);
            end
            CMD_NOTE_OFF: begin
               cmd_in.op = OP_FIND;
            end
            CMD_CONTROL_CHANGE: begin
               if (req_data1 == PEDAL_CC && req_data2 < PEDAL_ON) begin
                  cmd_in.op = OP_PEDAL_UP;
               end
            end
            CMD_PITCH_BEND: begin
               cmd_in.op   = OP_BEND;
               cmd_in.bend = {req_data2, req_data1};
            end
            CMD_RELEASE_VOICE: cmd_in.op = OP_REL_ONE;
            CMD_RELEASE_ALL:   cmd_in.op = OP_REL_ALL;
            CMD_READ_VOICE:    cmd_in.op = OP_READ;
            default:           cmd_in.op = OP_NONE;
         endcase
      end
   end

   // Voice choice and response from the finished scan record
   always_comb begin
      priority if (res_ff.note_found) begin
         target = res_ff.note_idx;
      end else if (res_ff.free_found) begin
         target = res_ff.free_idx;
      end else if (res_ff.nh_found) begin
         target = res_ff.nh_idx;
      end else begin
         target = res_ff.old_idx;
      end
      stolen = res_ff.note_found || !res_ff.free_found;
      act    = res_ff.active;
      result = '0;
      priority if (filt_ff) begin
         result.filtered = 1'b1;
      end else begin
         unique case (cmd_ff.op)
            OP_FIND: begin
               if (note_on_ff) begin
                  result.voice_index  = idx_to_out(target);
                  result.voice_hit    = 1'b1;
                  result.voice_stolen = stolen;
                  if (!stolen) begin
                     act = res_ff.active + CNT_W'(1);
                  end
               end else if (res_ff.note_found) begin
                  result.voice_index = idx_to_out(res_ff.note_idx);
                  result.voice_hit   = 1'b1;
                  if (!pedal_ff) begin
                     act = res_ff.active - CNT_W'(1);
                  end
               end
            end
            OP_PEDAL_UP: begin
               result.voice_hit      = res_ff.rel_hit;
               result.voice_index    = res_ff.rel_hit ? idx_to_out(res_ff.rel_first) : 4'd0;
               result.released_count = sat_count(res_ff.rel_cnt);
            end
            OP_REL_ONE: begin
               result.voice_index    = cmd_ff.sel;
               result.voice_hit      = res_ff.rel_hit;
               result.released_count = sat_count(res_ff.rel_cnt);
            end
            OP_REL_ALL: begin
               result.voice_hit      = (res_ff.rel_cnt != '0);
               result.released_count = sat_count(res_ff.rel_cnt);
            end
            OP_READ: begin
               result.voice_index = cmd_ff.sel;
               result.voice_hit   = res_ff.rd_hit;
               if (res_ff.rd_hit) begin
                  result.rd_active    = res_ff.rd_active;
                  result.rd_sustained = res_ff.rd_held;
                  result.rd_note      = res_ff.rd_key;
                  result.rd_velocity  = res_ff.rd_vel;
                  result.rd_channel   = res_ff.rd_chan;
                  result.rd_bend      = res_ff.rd_bend;
               end
            end
            OP_NONE, OP_BEND: begin
            end
            default: begin
            end
         endcase
      end
      result.active_count = sat_count(act);
   end

   // Sequencer: next state, channel state and response register
   always_comb begin
      state_in      = state_ff;
      seed_valid_in = 1'b0;
      res_in        = res_ff;
      chan_pedal_in = chan_pedal_ff;
      chan_bend_in  = chan_bend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr            = '0;
      req_take      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_take = req_valid;
            if (req_valid) begin
               seed_valid_in = 1'b1;
               state_in      = ST_SCAN;
               // channel state changes at acceptance
               if (!filt_in && code == CMD_CONTROL_CHANGE && req_data1 == PEDAL_CC) begin
                  chan_pedal_in[req_channel] = (req_data2 >= PEDAL_ON);
               end
               if (!filt_in && code == CMD_PITCH_BEND) begin
                  chan_bend_in[req_channel] = {req_data2, req_data1};
               end
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               res_in   = tail;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // single voice write for note on / note off
            if (cmd_ff.op == OP_FIND) begin
               if (note_on_ff) begin
                  wr.en   = 1'b1;
                  wr.idx  = target;
                  wr.mode = WR_NOTE_ON;
               end else if (res_ff.note_found) begin
                  wr.en   = 1'b1;
                  wr.idx  = res_ff.note_idx;
                  wr.mode = pedal_ff ? WR_HOLD : WR_RELEASE;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmd_ff        <= '0;
         seed_valid_ff <= 1'b0;
         note_on_ff    <= 1'b0;
         pedal_ff      <= 1'b0;
         filt_ff       <= 1'b0;
         res_ff        <= '0;
         chan_pedal_ff <= '0;
         chan_bend_ff  <= '{default: BEND_CENTRE};
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         seed_valid_ff <= seed_valid_in;
         res_ff        <= res_in;
         chan_pedal_ff <= chan_pedal_in;
         chan_bend_ff  <= chan_bend_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ff        <= rsp_in;
         if (req_take) begin
            cmd_ff     <= cmd_in;
            note_on_ff <= note_on_in;
            pedal_ff   <= pedal_in;
            filt_ff    <= filt_in;
         end
      end
   end

   // Fresh scan record into the first cell
   always_comb begin
      seed       = '0;
      seed.valid = seed_valid_ff;
   end

   assign cmd       = cmd_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/synth_voice_allocator_top.sv
// Voice allocator for a 16-voice synth (svalloc_pkg::VOICES). Requests are taken one at a
// time: each one sends a scan record down the row of voice cells, one cell per clock, and
// every cell compares or updates its own voice as the record passes. Every request then
// passes an apply step, in which a note on or note off writes the chosen voice, and a done
// step that loads the response register. The response register is loaded only once the
// previous response has been taken; until then the sequencer waits in its last step.
// Channel mask and omni mode are to be written over the CSR port only while idle; the
// block itself does not enforce this. There is no clearing pass after reset.
module synth_voice_allocator_top import svalloc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_data1,
   input  logic [6:0]  req_data2,
   input  logic [3:0]  req_voice_sel,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_voice_index,
   output logic        rsp_voice_hit,
   output logic        rsp_voice_stolen,
   output logic [4:0]  rsp_released_count,
   output logic [4:0]  rsp_active_count,
   output logic        rsp_filtered,
   output logic        rsp_rd_active,
   output logic        rsp_rd_sustained,
   output logic [6:0]  rsp_rd_note,
   output logic [6:0]  rsp_rd_velocity,
   output logic [3:0]  rsp_rd_channel,
   output logic [13:0] rsp_rd_bend,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]   mask_ff, mask_in;
   logic          omni_ff, omni_in;
   cmd_type       cmd;
   wr_type        wr;
   rsp_type       rsp;
   scan_type      link [VOICES+1];
   logic [VOICES:0] link_valid;

   // CSR registers
   always_comb begin
      mask_in = mask_ff;
      omni_in = omni_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_OMNI_MODE) begin
            omni_in = csr_pwdata[0];
         end else begin
            mask_in = csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 16'hFFFF;
         omni_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         omni_ff <= omni_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CHANNEL_MASK) ? {16'd0, mask_ff} : {31'd0, omni_ff};

   // Sequencer
   svalloc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_channel   (req_channel),
      .req_data1     (req_data1),
      .req_data2     (req_data2),
      .req_voice_sel (req_voice_sel),
      .req_now       (req_now),
      .channel_mask  (mask_ff),
      .omni_mode     (omni_ff),
      .cmd           (cmd),
      .seed          (link[0]),
      .tail          (link[VOICES]),
      .wr            (wr),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp)
   );

   // Row of voice cells
   for (genvar k = 0; k < VOICES; k++) begin : g_cell
      svalloc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (VIDX_W'(k)),
         .cmd      (cmd),
         .wr       (wr),
         .prev_rec (link[k]),
         .next_rec (link[k+1])
      );
   end

   for (genvar k = 0; k <= VOICES; k++) begin : g_valid
      assign link_valid[k] = link[k].valid;
   end

   assign rsp_voice_index    = rsp.voice_index;
   assign rsp_voice_hit      = rsp.voice_hit;
   assign rsp_voice_stolen   = rsp.voice_stolen;
   assign rsp_released_count = rsp.released_count;
   assign rsp_active_count   = rsp.active_count;
   assign rsp_filtered       = rsp.filtered;
   assign rsp_rd_active      = rsp.rd_active;
   assign rsp_rd_sustained   = rsp.rd_sustained;
   assign rsp_rd_note        = rsp.rd_note;
   assign rsp_rd_velocity    = rsp.rd_velocity;
   assign rsp_rd_channel     = rsp.rd_channel;
   assign rsp_rd_bend        = rsp.rd_bend;

   // At most one scan record in the row
   a_one_record: assert property (@(posedge clock) disable iff (reset)
      $onehot0(link_valid))
      else $error("more than one scan record in flight");

   // Idle means the row is empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (link_valid == '0))
      else $error("request taken while a scan is in flight");

   // Voice writes never race a scan
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (link_valid == '0))
      else $error("voice write during a scan");

   // A stolen voice is always a hit on an active voice
   a_stolen_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_voice_stolen) |-> (rsp_voice_hit && rsp_active_count != 5'd0))
      else $error("stolen voice without a hit");

endmodule
